@@ sv/swrp_pkg.sv @@
// Shared types and constants for the stack with running product.
// No dependencies; imported by swrp_ctrl, swrp_dpath and the top level.
package swrp_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] KIND_PUSH    = 3'd0;
    localparam logic [2:0] KIND_POP     = 3'd1;
    localparam logic [2:0] KIND_TOP     = 3'd2;
    localparam logic [2:0] KIND_WRITE   = 3'd3;
    localparam logic [2:0] KIND_PRODUCT = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [63:0] value;
    } t_in;

    typedef struct packed {
        logic signed [63:0] data;
        logic [1:0]         status;
        logic [7:0]         fill;
    } t_out;

    typedef enum logic [1:0] {
        MS_NONE,
        MS_LL,
        MS_LH,
        MS_HL
    } t_mstep;

    typedef struct packed {
        logic   load;
        t_mstep mstep;
        logic   finish;
    } t_cmd;

    typedef struct packed {
        logic need_mul;
    } t_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL_LH,
        S_MUL_HL,
        S_COMMIT
    } t_state;

endpackage

@@ sv/swrp_ctrl.sv @@
// Controller state machine for the stack with running product.
// Depends on swrp_pkg; drives the command struct of swrp_dpath.
module swrp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  swrp_pkg::t_stat i_stat,
    output swrp_pkg::t_cmd  o_cmd
);
    import swrp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.mstep  = MS_NONE;
        o_cmd.finish = 1'b0;
        busy         = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.need_mul) begin
                    o_cmd.mstep = MS_LL;
                    n_state     = S_MUL_LH;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_MUL_LH: begin
                o_cmd.mstep = MS_LH;
                n_state     = S_MUL_HL;
            end
            S_MUL_HL: begin
                o_cmd.mstep = MS_HL;
                n_state     = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/swrp_dpath.sv @@
// Datapath: value and product memories, entry count, shared 32x32 multiplier,
// result register. Depends on swrp_pkg; commanded by swrp_ctrl.
module swrp_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  swrp_pkg::t_in   i_item,
    input  swrp_pkg::t_cmd  i_cmd,
    output swrp_pkg::t_stat o_stat,
    output swrp_pkg::t_out  o_result,
    output logic            o_valid
);
    import swrp_pkg::*;

    logic [63:0] value_mem [STACK_DEPTH];
    logic [63:0] prod_mem  [STACK_DEPTH];

    logic [2:0]         r_kind;
    logic signed [63:0] r_value;
    logic [63:0]        r_rd_val;
    logic [63:0]        r_rd_prod;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [63:0]        r_acc;
    logic [31:0]        r_x;
    t_out               r_out, n_out;
    logic               r_valid;

    logic [ADDR_W-1:0] rd_addr_v, rd_addr_p, wr_addr;
    logic              wr_en;
    logic [63:0]       wr_prod;
    logic              empty, full;
    logic [31:0]       m_a, m_b;
    logic [63:0]       m_p;

    assign empty = (r_count == '0);
    assign full  = (r_count == CNT_W'(STACK_DEPTH));

    assign o_stat.need_mul = ((r_kind == KIND_PUSH) && !empty && !full)
                           || ((r_kind == KIND_WRITE) && (r_count >= CNT_W'(2)));

    // write top needs the product of the entry below the top
    assign rd_addr_v = ADDR_W'(r_count - CNT_W'(1));
    assign rd_addr_p = (i_item.kind == KIND_WRITE) ? ADDR_W'(r_count - CNT_W'(2))
                                                   : ADDR_W'(r_count - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_item.kind;
            r_value   <= i_item.value;
            r_rd_val  <= value_mem[rd_addr_v];
            r_rd_prod <= prod_mem[rd_addr_p];
        end
    end

    // low 64 bits of r_rd_prod * r_value in three passes
    always_comb begin
        case (i_cmd.mstep)
            MS_LH: begin
                m_a = r_rd_prod[31:0];
                m_b = r_value[63:32];
            end
            MS_HL: begin
                m_a = r_rd_prod[63:32];
                m_b = r_value[31:0];
            end
            default: begin
                m_a = r_rd_prod[31:0];
                m_b = r_value[31:0];
            end
        endcase
    end

    assign m_p = m_a * m_b;

    always_ff @(posedge i_clk) begin
        case (i_cmd.mstep)
            MS_LL:   r_acc <= m_p;
            MS_LH:   r_x   <= m_p[31:0];
            MS_HL:   r_acc[63:32] <= r_acc[63:32] + r_x + m_p[31:0];
            default: ;
        endcase
    end

    assign wr_prod = o_stat.need_mul ? r_acc : r_value;

    always_comb begin
        n_count       = r_count;
        wr_en         = 1'b0;
        wr_addr       = ADDR_W'(r_count);
        n_out.data    = '0;
        n_out.status  = ST_OK;
        case (r_kind)
            KIND_PUSH: begin
                if (full) begin
                    n_out.status = ST_OVER;
                end else begin
                    wr_en      = 1'b1;
                    n_out.data = wr_prod;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            KIND_POP: begin
                if (empty) begin
                    n_out.status = ST_UNDER;
                end else begin
                    n_out.data = r_rd_val;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            KIND_TOP: begin
                if (empty) begin
                    n_out.status = ST_UNDER;
                end else begin
                    n_out.data = r_rd_val;
                end
            end
            KIND_WRITE: begin
                if (empty) begin
                    n_out.status = ST_UNDER;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = rd_addr_v;
                    n_out.data = r_value;
                end
            end
            KIND_PRODUCT: begin
                if (empty) begin
                    n_out.status = ST_UNDER;
                end else begin
                    n_out.data = r_rd_prod;
                end
            end
            default: ;
        endcase
        n_out.fill = 8'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && wr_en) begin
            value_mem[wr_addr] <= r_value;
            prod_mem[wr_addr]  <= wr_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_valid;

endmodule

@@ sv/stack_with_running_product.sv @@
// Stack with running product: top level joining swrp_ctrl and swrp_dpath.
// Each accepted item gives one result strobe; a push or write top that
// multiplies first makes three passes through one 32x32 multiplier.
// A new item is taken only in idle: busy stays high until the last one finishes.
// Reset (synchronous, active low) empties the stack; memories are not cleared.
// The receiver cannot stall: o_valid is high for one cycle per item.
module stack_with_running_product (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  swrp_pkg::t_in  i_item,
    output swrp_pkg::t_out o_result,
    output logic           o_valid
);
    import swrp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    swrp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    swrp_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule
